[rtl/prq_pkg.sv]
package prq_pkg;

   localparam int ID_W     = 8;
   localparam int PRI_W    = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] pri;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

[rtl/prq_ram.sv]
module prq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/prq_slot_map.sv]
module prq_slot_map #(
   parameter int DEPTH = 16
) (
   input  logic [$clog2(DEPTH)-1:0] head,
   input  logic [$clog2(DEPTH)-1:0] slot,
   output logic [$clog2(DEPTH)-1:0] addr
);

   localparam int AW = $clog2(DEPTH);

   logic [AW:0] sum;
   logic [AW:0] wrapped;

   // logical slot to ring address: one add, one compare and subtract
   always_comb begin
      sum     = {1'b0, head} + {1'b0, slot};
      wrapped = sum - (AW+1)'(DEPTH);
      addr    = (sum >= (AW+1)'(DEPTH)) ? wrapped[AW-1:0] : sum[AW-1:0];
   end

endmodule

[rtl/priority_ready_queue_core.sv]
// Stable priority ready queue of up to DEPTH entries held in a ring buffer in one RAM.
// Pulse start while busy is low; exactly one result comes back on rsp_valid for one
// cycle, in the first cycle that busy is low again, and it cannot be stalled, so sample
// it then. A dequeue keeps busy high for 1 cycle. An enqueue walks from the tail toward
// the head, moving each lower-priority entry up one slot: each move is a read step
// (ST_ENQ_STEP) then a write step (ST_ENQ_CMP) through the single RAM port pair, and
// the walk ends by writing the new entry in its slot, or at the head if it gets there.
// Rejected items (dequeue when empty, enqueue when full) report the cycle after start.
module priority_ready_queue_core #(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_operation,
   input  logic [prq_pkg::ID_W-1:0]       req_proc_id,
   input  logic [prq_pkg::PRI_W-1:0]      req_proc_priority,
   output logic                           rsp_valid,
   output logic [prq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [prq_pkg::ID_W-1:0]       rsp_head_id,
   output logic [prq_pkg::PRI_W-1:0]      rsp_head_priority,
   output logic [prq_pkg::OCC_W-1:0]      rsp_occupancy
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENQ_STEP,
      ST_ENQ_CMP,
      ST_DEQ_DONE
   } state_type;

   state_type             state_ff,  state_in;
   logic [AW-1:0]         head_ff,   head_in;
   logic [CW-1:0]         count_ff,  count_in;
   logic [AW-1:0]         slot_ff,   slot_in;
   prq_pkg::entry_type    new_ff,    new_in;
   logic                  valid_ff,  valid_in;
   logic [prq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [prq_pkg::ID_W-1:0]     hid_ff,    hid_in;
   logic [prq_pkg::PRI_W-1:0]    hpri_ff,   hpri_in;
   logic [prq_pkg::OCC_W-1:0]    occ_ff,    occ_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   prq_pkg::entry_type    wr_entry;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [prq_pkg::ENTRY_W-1:0] rd_data;
   prq_pkg::entry_type    rd_entry;

   logic [AW-1:0]         map_slot;
   logic [AW-1:0]         map_addr;
   logic [CW-1:0]         count_up;
   logic [CW-1:0]         count_dn;

   assign rd_entry = prq_pkg::entry_type'(rd_data);
   assign count_up = count_ff + CW'(1);
   assign count_dn = count_ff - CW'(1);
   assign map_slot = (state_ff == ST_ENQ_CMP) ? slot_ff : slot_ff - AW'(1);

   prq_slot_map #(.DEPTH(DEPTH)) u_slot_map (
      .head (head_ff),
      .slot (map_slot),
      .addr (map_addr)
   );

   prq_ram #(.WIDTH(prq_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      slot_in   = slot_ff;
      new_in    = new_ff;
      valid_in  = 1'b0;
      status_in = status_ff;
      hid_in    = hid_ff;
      hpri_in   = hpri_ff;
      occ_in    = occ_ff;
      wr_en     = 1'b0;
      wr_addr   = map_addr;
      wr_entry  = new_ff;
      rd_en     = 1'b0;
      rd_addr   = map_addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               new_in.id  = req_proc_id;
               new_in.pri = req_proc_priority;
               status_in  = prq_pkg::STATUS_OK;
               hid_in     = '0;
               hpri_in    = '0;
               occ_in     = prq_pkg::OCC_W'(count_ff);
               if (req_operation == prq_pkg::OP_ENQUEUE) begin
                  if (count_ff == CW'(DEPTH)) begin
                     status_in = prq_pkg::STATUS_FULL;
                     valid_in  = 1'b1;
                  end else begin
                     slot_in  = count_ff[AW-1:0];
                     state_in = ST_ENQ_STEP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = prq_pkg::STATUS_EMPTY;
                     valid_in  = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     state_in = ST_DEQ_DONE;
                  end
               end
            end
         end
         ST_ENQ_STEP: begin
            if (slot_ff == '0) begin
               // reached the head: new entry goes first
               wr_en    = 1'b1;
               wr_addr  = head_ff;
               count_in = count_up;
               occ_in   = prq_pkg::OCC_W'(count_up);
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_ENQ_CMP;
            end
         end
         ST_ENQ_CMP: begin
            wr_en = 1'b1;
            if (rd_entry.pri >= new_ff.pri) begin
               count_in = count_up;
               occ_in   = prq_pkg::OCC_W'(count_up);
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               // move the lower-priority entry up one slot
               wr_entry = rd_entry;
               slot_in  = slot_ff - AW'(1);
               state_in = ST_ENQ_STEP;
            end
         end
         ST_DEQ_DONE: begin
            hid_in   = rd_entry.id;
            hpri_in  = rd_entry.pri;
            head_in  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
            count_in = count_dn;
            occ_in   = prq_pkg::OCC_W'(count_dn);
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      slot_ff   <= slot_in;
      new_ff    <= new_in;
      status_ff <= status_in;
      hid_ff    <= hid_in;
      hpri_ff   <= hpri_in;
      occ_ff    <= occ_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_head_id       = hid_ff;
   assign rsp_head_priority = hpri_ff;
   assign rsp_occupancy     = occ_ff;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int QUEUE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 500000;

   class ready_queue_tracker;
      typedef struct {
         logic [prq_pkg::STATUS_W-1:0] status;
         logic [prq_pkg::ID_W-1:0]     head_id;
         logic [prq_pkg::PRI_W-1:0]    head_priority;
         logic [prq_pkg::OCC_W-1:0]    occupancy;
      } queue_reply_type;

      logic [prq_pkg::ID_W-1:0]  slot_id[QUEUE_DEPTH];
      logic [prq_pkg::PRI_W-1:0] slot_pri[QUEUE_DEPTH];
      int                        fill;
      int                        mismatches;
      queue_reply_type           expected_replies[$];

      function int pending();
         return expected_replies.size();
      endfunction

      // Predict the reply of one accepted transaction and update the ready list.
      function void note_request(logic op, logic [prq_pkg::ID_W-1:0] id,
                                 logic [prq_pkg::PRI_W-1:0] pri);
         queue_reply_type reply;
         int              pos;
         reply.status        = prq_pkg::STATUS_OK;
         reply.head_id       = '0;
         reply.head_priority = '0;
         if (op == prq_pkg::OP_ENQUEUE) begin
            if (fill >= QUEUE_DEPTH) begin
               reply.status = prq_pkg::STATUS_FULL;
            end else begin
               pos = 0;
               // land after every entry of equal or higher priority
               while (pos < fill && slot_pri[pos] >= pri) pos++;
               for (int i = fill; i > pos; i--) begin
                  slot_id[i]  = slot_id[i-1];
                  slot_pri[i] = slot_pri[i-1];
               end
               slot_id[pos]  = id;
               slot_pri[pos] = pri;
               fill++;
            end
         end else if (fill == 0) begin
            reply.status = prq_pkg::STATUS_EMPTY;
         end else begin
            reply.head_id       = slot_id[0];
            reply.head_priority = slot_pri[0];
            for (int i = 1; i < fill; i++) begin
               slot_id[i-1]  = slot_id[i];
               slot_pri[i-1] = slot_pri[i];
            end
            fill--;
         end
         reply.occupancy = prq_pkg::OCC_W'(fill);
         expected_replies.push_back(reply);
      endfunction

      function void check_result(logic [prq_pkg::STATUS_W-1:0] status,
                                 logic [prq_pkg::ID_W-1:0] id,
                                 logic [prq_pkg::PRI_W-1:0] pri,
                                 logic [prq_pkg::OCC_W-1:0] occ);
         queue_reply_type want;
         if (expected_replies.size() == 0) begin
            $error("unexpected reply: status %0d id %0d priority %0d occupancy %0d",
                   status, id, pri, occ);
            mismatches++;
            return;
         end
         want = expected_replies.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
         end
         if (id !== want.head_id) begin
            $error("head_id: expected %0d, got %0d", want.head_id, id);
            mismatches++;
         end
         if (pri !== want.head_priority) begin
            $error("head_priority: expected %0d, got %0d", want.head_priority, pri);
            mismatches++;
         end
         if (occ !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occ);
            mismatches++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_operation;
   logic [prq_pkg::ID_W-1:0]     req_proc_id;
   logic [prq_pkg::PRI_W-1:0]    req_proc_priority;
   logic                         rsp_valid;
   logic [prq_pkg::STATUS_W-1:0] rsp_status;
   logic [prq_pkg::ID_W-1:0]     rsp_head_id;
   logic [prq_pkg::PRI_W-1:0]    rsp_head_priority;
   logic [prq_pkg::OCC_W-1:0]    rsp_occupancy;
   int                           cycle_count = 0;

   ready_queue_tracker queue_tracker = new;

   priority_ready_queue_core #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_proc_id       (req_proc_id),
      .req_proc_priority (req_proc_priority),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_head_id       (rsp_head_id),
      .rsp_head_priority (rsp_head_priority),
      .rsp_occupancy     (rsp_occupancy)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         queue_tracker.check_result(rsp_status, rsp_head_id, rsp_head_priority,
                                    rsp_occupancy);
   end

   // Hold the transaction on the ports until the block takes it.
   task automatic issue(input logic op, input logic [prq_pkg::ID_W-1:0] id,
                        input logic [prq_pkg::PRI_W-1:0] pri);
      req_operation     <= op;
      req_proc_id       <= id;
      req_proc_priority <= pri;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      queue_tracker.note_request(op, id, pri);
   endtask

   task automatic maybe_idle(input int idle_pct);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (queue_tracker.pending() != 0);
   endtask

   task automatic issue_random(input int enq_pct);
      logic                      op;
      logic [prq_pkg::PRI_W-1:0] pri;
      op = ($urandom_range(0, 99) < enq_pct) ? prq_pkg::OP_ENQUEUE : prq_pkg::OP_DEQUEUE;
      case ($urandom_range(0, 3))
         0: begin
            pri = prq_pkg::PRI_W'($urandom_range(0, 255));
         end
         1: begin
            pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: begin
            // crowd a few values together so ties stay common
            pri = prq_pkg::PRI_W'($urandom_range(100, 103));
         end
      endcase
      issue(op, prq_pkg::ID_W'($urandom_range(0, 255)), pri);
   endtask

   initial begin
      int idle_pct[4];
      int enq_pct;
      idle_pct          = '{0, 61, 0, 24};
      reset             <= 1'b1;
      start             <= 1'b0;
      req_operation     <= prq_pkg::OP_ENQUEUE;
      req_proc_id       <= '0;
      req_proc_priority <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      issue(prq_pkg::OP_DEQUEUE, 8'h00, 8'h00);
      issue(prq_pkg::OP_ENQUEUE, 8'hFF, 8'h00);
      issue(prq_pkg::OP_ENQUEUE, 8'h00, 8'hFF);
      issue(prq_pkg::OP_ENQUEUE, 8'hAA, 8'h80);
      issue(prq_pkg::OP_ENQUEUE, 8'h55, 8'h80);
      issue(prq_pkg::OP_ENQUEUE, 8'h11, 8'h00);
      for (int i = 0; i < QUEUE_DEPTH - 5; i++)
         issue(prq_pkg::OP_ENQUEUE, prq_pkg::ID_W'($urandom_range(0, 255)),
               prq_pkg::PRI_W'($urandom_range(0, 255)));
      issue(prq_pkg::OP_ENQUEUE, 8'h77, 8'hFF);
      repeat (5)
         issue(prq_pkg::OP_DEQUEUE, prq_pkg::ID_W'($urandom_range(0, 255)),
               prq_pkg::PRI_W'($urandom_range(0, 255)));
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         enq_pct = 50;
         for (int n = 0; n < 150; n++) begin
            // drift the mix so the queue swings between empty and full
            if (n % 25 == 0) enq_pct = $urandom_range(10, 90);
            maybe_idle(idle_pct[phase]);
            issue_random(enq_pct);
         end
         wait_drained();
      end

      start <= 1'b0;
      repeat (80) @(posedge clock);
      if (queue_tracker.mismatches == 0 && queue_tracker.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
rtl/prq_pkg.sv
rtl/prq_ram.sv
rtl/prq_slot_map.sv
rtl/priority_ready_queue_core.sv
test/tb.sv
